/* hdl/assert_macros.svh */
// assertion macros used by the top level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define OBSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define OBSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/obsp_pkg.sv */
// package for the ordered bit set core: widths, action codes, controller states
`timescale 1ns / 1ps

package obsp_pkg;

	localparam int unsigned KEY_W        = 12;
	localparam int unsigned ACTION_W     = 3;
	localparam int unsigned UNIVERSE_DEF = 4096;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT   = 3'd0,
		ACT_ERASE    = 3'd1,
		ACT_CONTAINS = 3'd2,
		ACT_SUCC     = 3'd3,
		ACT_PRED     = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEAF,
		ST_UPD,
		ST_CLIMB,
		ST_SIB,
		ST_DOWN,
		ST_EMIT
	} state_t;

endpackage

/* hdl/obsp_count_ram.sv */
// node count memory: one write port, one read port with registered data
`timescale 1ns / 1ps

module obsp_count_ram #(
	parameter int unsigned AW = 13,
	parameter int unsigned CW = 13
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [CW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [CW-1:0] rd_data
);

	logic [CW-1:0] mem [2**AW];
	logic [CW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/ordered_bit_set_predecessor_core.sv */
// top level of the ordered bit set: count tree in memory, walk controller, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | direction | beat                       | handshake
//  cmd     | in        | action, key                | cmd_valid / cmd_ready
//  res     | out       | found, position            | res_valid / res_ready
//
//  one command is worked at a time; insert and erase read the leaf and go back
//  to idle when the set does not change, and else update each count on the
//  path up to the root; contains reads the leaf only; successor and predecessor
//  climb and descend the tree with a single memory read per step
//  after reset the whole memory (2 * 2**D entries, D = clog2(UNIVERSE)) is
//  swept to zero, one entry a cycle, with cmd_ready low
//  a waiting result sits in the output register, so a new command is taken
//  while res_ready is low; only the next result then waits for it

module ordered_bit_set_predecessor_core #(
	parameter int unsigned UNIVERSE = obsp_pkg::UNIVERSE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [obsp_pkg::ACTION_W-1:0] action,
	input  logic [obsp_pkg::KEY_W-1:0]    key,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       found,
	output logic [obsp_pkg::KEY_W-1:0]    position
);

	import obsp_pkg::*;

	// tree geometry: heap layout, root at 1, leaf of key k at 2**D + k
	localparam int unsigned D  = $clog2(UNIVERSE);
	localparam int unsigned AW = D + 1;
	localparam int unsigned CW = $clog2(UNIVERSE + 1);
	localparam int unsigned EW = (D > KEY_W) ? D : KEY_W;

	localparam logic [AW-1:0] ROOT    = AW'(1);
	localparam logic [AW-1:0] LSB     = AW'(1);
	localparam logic [D-1:0]  KEY_TOP = D'(UNIVERSE - 1);
	localparam logic [EW:0]   U_EXT   = (EW+1)'(UNIVERSE);

	state_t state_q, state_d;
	action_t act_q, act_d;
	logic [AW-1:0] node_q, node_d;
	logic [AW-1:0] clr_q;
	logic res_found_q, res_found_d;
	logic [KEY_W-1:0] res_pos_q, res_pos_d;
	logic res_valid_q;
	logic found_q;
	logic [KEY_W-1:0] position_q;

	// memory ports
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] wr_data;
	logic [CW-1:0] rd_data;

	// command decode
	logic [EW-1:0] key_ext;
	logic in_range;
	logic [D-1:0] key_eff;
	logic [AW-1:0] in_leaf;

	// walk helpers
	logic pbit;
	logic rd_nz;
	logic ins;
	logic [AW-1:0] parent;
	logic [AW-1:0] sib;
	logic [AW-1:0] chosen;
	logic out_free;

	function automatic logic [KEY_W-1:0] leaf_key(input logic [AW-1:0] n);
		logic [EW-1:0] ext;
		ext = EW'(n[D-1:0]);
		return ext[KEY_W-1:0];
	endfunction

	function automatic logic [AW-1:0] child_of(input logic [AW-1:0] n, input logic b);
		return {n[AW-2:0], b};
	endfunction

	assign key_ext  = EW'(key);
	assign in_range = (EW+1)'(key_ext) < U_EXT;
	// out-of-range predecessor searches from the top key
	assign key_eff  = in_range ? key_ext[D-1:0] : KEY_TOP;
	assign in_leaf  = {1'b1, key_eff};

	assign pbit     = (act_q == ACT_PRED);
	assign rd_nz    = (rd_data != '0);
	assign ins      = (act_q == ACT_INSERT);
	assign parent   = {1'b0, node_q[AW-1:1]};
	assign sib      = node_q ^ LSB;
	// preferred child empty means the other one holds the members
	assign chosen   = rd_nz ? node_q : sib;
	assign out_free = !res_valid_q || res_ready;

	// next state and walk datapath; every read targets node_d
	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		node_d      = node_q;
		res_found_d = res_found_q;
		res_pos_d   = res_pos_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				node_d = in_leaf;
				if (cmd_valid) begin
					act_d       = action_t'(action);
					res_found_d = 1'b0;
					res_pos_d   = '0;
					priority case (action_t'(action))
						ACT_INSERT, ACT_ERASE: begin
							if (in_range) begin
								state_d = ST_LEAF;
							end
						end
						ACT_CONTAINS, ACT_SUCC: begin
							state_d = in_range ? ST_LEAF : ST_EMIT;
						end
						ACT_PRED: begin
							state_d = ST_LEAF;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LEAF: begin
				priority case (act_q)
					ACT_INSERT, ACT_ERASE: begin
						if (rd_nz == ins) begin
							state_d = ST_IDLE;
						end else begin
							node_d  = parent;
							state_d = ST_UPD;
						end
					end
					ACT_CONTAINS: begin
						res_found_d = rd_nz;
						state_d     = ST_EMIT;
					end
					ACT_SUCC, ACT_PRED: begin
						if (rd_nz) begin
							res_found_d = 1'b1;
							res_pos_d   = leaf_key(node_q);
							state_d     = ST_EMIT;
						end else begin
							state_d = ST_CLIMB;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_UPD: begin
				if (node_q == ROOT) begin
					state_d = ST_IDLE;
				end else begin
					node_d = parent;
				end
			end
			ST_CLIMB: begin
				if (node_q == ROOT) begin
					state_d = ST_EMIT;
				end else if (node_q[0] == pbit) begin
					// sibling lies on the search side
					node_d  = sib;
					state_d = ST_SIB;
				end else begin
					node_d = parent;
				end
			end
			ST_SIB: begin
				if (!rd_nz) begin
					node_d  = parent;
					state_d = ST_CLIMB;
				end else if (node_q[AW-1]) begin
					res_found_d = 1'b1;
					res_pos_d   = leaf_key(node_q);
					state_d     = ST_EMIT;
				end else begin
					node_d  = child_of(node_q, pbit);
					state_d = ST_DOWN;
				end
			end
			ST_DOWN: begin
				if (chosen[AW-1]) begin
					res_found_d = 1'b1;
					res_pos_d   = leaf_key(chosen);
					state_d     = ST_EMIT;
				end else begin
					node_d = child_of(chosen, pbit);
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory writes
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_LEAF: begin
				if ((act_q == ACT_INSERT || act_q == ACT_ERASE) && rd_nz != ins) begin
					wr_en   = 1'b1;
					wr_data = CW'(ins);
				end
			end
			ST_UPD: begin
				wr_en   = 1'b1;
				wr_data = ins ? rd_data + CW'(1) : rd_data - CW'(1);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + LSB;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_q       <= act_d;
		node_q      <= node_d;
		res_found_q <= res_found_d;
		res_pos_q   <= res_pos_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign res_valid = res_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	obsp_count_ram #(
		.AW(AW),
		.CW(CW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(node_d),
		.rd_data(rd_data)
	);

	`OBSP_ASSERT_IMP(a_idle_no_write, cmd_ready, !wr_en, "memory written while taking commands")
	`OBSP_ASSERT_IMP(a_pos_zero, res_valid && !found, position == '0, "not-found result with nonzero position")
	`OBSP_ASSERT_IMP(a_node_valid, state_q != ST_CLEAR && state_q != ST_IDLE, node_q != '0, "walk reached unused node zero")

endmodule
